### sv/tsq_pkg.sv
// Shared types, constants and command codes of the tone sequencer.
package tsq_pkg;

    localparam int MAX_NOTES = 64;
    localparam int ADDR_W    = $clog2(MAX_NOTES);
    localparam int POS_W     = $clog2(MAX_NOTES + 1);
    localparam int NOTE_W    = 43;
    localparam int DIV_W     = 48;
    localparam int DIVR_W    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PLAY = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    localparam logic [1:0] ENV_RISE = 2'd0;
    localparam logic [1:0] ENV_FALL = 2'd1;

    localparam logic [1:0] REG_TIMER_CLOCK = 2'd0;
    localparam logic [1:0] REG_AMP_PERIOD  = 2'd1;
    localparam logic [1:0] REG_VOLUME      = 2'd2;

    localparam logic [15:0] REST_BASE_HZ = 16'd1000;
    localparam logic [31:0] MS_PER_S     = 32'd1000;
    localparam logic [8:0]  Q8_ONE       = 9'd256;

    // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38; the
    // result is exact for every 32-bit dividend.
    localparam logic [28:0] MS_RECIP = 29'd274877907;
    localparam int          MS_SHIFT = 38;
    localparam int          CPROD_W  = 61;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  note_index;
        logic [15:0] note_freq;
        logic [15:0] note_duration_ms;
        logic [8:0]  note_amp;
        logic [1:0]  note_envelope;
        logic [6:0]  play_length;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] period_reload;
        logic [15:0] duty_compare;
        logic        tone_on;
        logic        playing;
        logic        sequence_done;
    } out_beat_t;

    typedef struct packed {
        logic [27:0] timer_clock_hz;
        logic [15:0] amp_timer_period;
        logic [8:0]  volume;
    } cfg_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
        logic [8:0]  amp;
        logic [1:0]  env;
    } note_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_PLAY,
        OP_STOP,
        OP_HALF,
        OP_TICK,
        OP_LATCH,
        OP_LATCH_ENV,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_RELOAD,
        OP_SET_RELOAD,
        OP_MUL_COUNT,
        OP_SET_COUNT,
        OP_ENV_MUL,
        OP_DIV_ENV,
        OP_SET_COMPARE,
        OP_ADVANCE,
        OP_END,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD,
        ST_LATCH,
        ST_MUL1,
        ST_MUL2,
        ST_DRL,
        ST_DRL_W,
        ST_DCT,
        ST_DCT_W,
        ST_ENVM,
        ST_DEV,
        ST_DEV_W,
        ST_TRD,
        ST_TLATCH,
        ST_ADV,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       playing;
        logic       half;
        logic       div_done;
        logic       remain_zero;
        logic       pos_end;
        logic       len_zero;
        logic       out_free;
    } stat_t;

endpackage

### sv/tsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/tsq_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module tsq_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsq_pkg::DIV_W-1:0]  dividend,
    input  logic [tsq_pkg::DIVR_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [tsq_pkg::DIV_W-1:0]  quotient
);

    logic [tsq_pkg::DIVR_W-1:0]    rem_reg;
    logic [tsq_pkg::DIV_W-1:0]     quo_reg;
    logic [tsq_pkg::DIVR_W-1:0]    dvs_reg;
    logic [tsq_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [tsq_pkg::DIVR_W:0]      shifted;
    logic [tsq_pkg::DIVR_W:0]      diff;
    logic                          fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[tsq_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[tsq_pkg::DIVR_W-1:0] : shifted[tsq_pkg::DIVR_W-1:0];
                quo_reg <= {quo_reg[tsq_pkg::DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tsq_pkg::DIV_CNT_W'(tsq_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/tsq_datapath.sv
// Datapath of the tone sequencer: note table, playback state, arithmetic and result register.
module tsq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsq_pkg::cfg_t       cfg,
    input  tsq_pkg::in_beat_t   s_data,
    input  tsq_pkg::cmd_t       cmd,
    output tsq_pkg::stat_t      stat,
    input  logic                m_ready,
    output logic                m_valid,
    output tsq_pkg::out_beat_t  m_data
);

    tsq_pkg::in_beat_t  in_reg;
    tsq_pkg::note_t     note_reg;
    tsq_pkg::note_t     ram_wdata;
    tsq_pkg::note_t     ram_rdata;
    tsq_pkg::out_beat_t m_data_reg;
    logic [31:0] fd_reg;
    logic [16:0] av_reg;
    logic [15:0] peak_reg;
    logic [31:0] reload_reg;
    logic [15:0] compare_reg;
    logic [31:0] remain_reg;
    logic [31:0] total_reg;
    logic [tsq_pkg::POS_W-1:0] pos_reg;
    logic [tsq_pkg::POS_W-1:0] len_reg;
    logic        half_reg;
    logic        playing_reg;
    logic        tone_reg;
    logic        done_reg;
    logic [47:0] envp_reg;
    logic [tsq_pkg::CPROD_W-1:0] cnt_prod_reg;
    logic        m_valid_reg;

    logic        is_rest;
    logic [15:0] f_eff;
    logic [8:0]  amp_sat;
    logic [8:0]  vol_sat;
    logic [31:0] peak_full;
    logic [31:0] env_mult;
    logic [31:0] count_raw;
    logic [31:0] count_fix;
    logic [tsq_pkg::POS_W-1:0] len_sat;
    logic        len_zero;
    logic        ram_we;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [tsq_pkg::DIV_W-1:0]  div_dividend;
    logic [tsq_pkg::DIVR_W-1:0] div_divisor;
    logic [tsq_pkg::DIV_W-1:0]  div_quotient;

    assign ram_we    = (cmd.op == tsq_pkg::OP_LOAD) &&
                       (32'(in_reg.note_index) < tsq_pkg::MAX_NOTES);
    assign ram_wdata = '{freq: in_reg.note_freq, dur: in_reg.note_duration_ms,
                         amp: in_reg.note_amp, env: in_reg.note_envelope};

    tsq_ram #(.WIDTH(tsq_pkg::NOTE_W), .DEPTH(tsq_pkg::MAX_NOTES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tsq_pkg::ADDR_W'(in_reg.note_index)),
        .wdata (ram_wdata),
        .raddr (pos_reg[tsq_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        is_rest   = note_reg.freq == 16'd0;
        f_eff     = is_rest ? tsq_pkg::REST_BASE_HZ : note_reg.freq;
        amp_sat   = (note_reg.amp > tsq_pkg::Q8_ONE) ? tsq_pkg::Q8_ONE : note_reg.amp;
        vol_sat   = (cfg.volume > tsq_pkg::Q8_ONE) ? tsq_pkg::Q8_ONE : cfg.volume;
        peak_full = {16'd0, cfg.amp_timer_period} * {15'd0, av_reg};
        case (note_reg.env)
            tsq_pkg::ENV_RISE: env_mult = total_reg - remain_reg;
            tsq_pkg::ENV_FALL: env_mult = remain_reg;
            default:           env_mult = total_reg;
        endcase
        count_raw = is_rest ? 32'(note_reg.dur) :
                    32'(cnt_prod_reg[tsq_pkg::CPROD_W-1:tsq_pkg::MS_SHIFT]);
        count_fix = (count_raw == 32'd0) ? 32'd1 : count_raw;
        len_zero  = in_reg.play_length == 7'd0;
        len_sat   = (32'(in_reg.play_length) > tsq_pkg::MAX_NOTES) ?
                    tsq_pkg::POS_W'(tsq_pkg::MAX_NOTES) :
                    tsq_pkg::POS_W'(in_reg.play_length);
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            tsq_pkg::OP_DIV_RELOAD: begin
                div_start    = 1'b1;
                div_dividend = 48'(cfg.timer_clock_hz);
                div_divisor  = 32'({f_eff, 1'b0});
            end
            tsq_pkg::OP_DIV_ENV: begin
                div_start    = 1'b1;
                div_dividend = envp_reg;
                div_divisor  = total_reg;
            end
            default: ;
        endcase
    end

    tsq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg  <= '0;
            compare_reg <= '0;
            remain_reg  <= '0;
            total_reg   <= '0;
            peak_reg    <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
            half_reg    <= 1'b0;
            playing_reg <= 1'b0;
            tone_reg    <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && cmd.op != tsq_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                tsq_pkg::OP_CAPTURE: begin
                    in_reg   <= s_data;
                    done_reg <= 1'b0;
                end
                tsq_pkg::OP_PLAY: begin
                    done_reg    <= playing_reg & len_zero;
                    compare_reg <= '0;
                    tone_reg    <= 1'b0;
                    playing_reg <= !len_zero;
                    if (!len_zero) begin
                        pos_reg  <= '0;
                        len_reg  <= len_sat;
                        half_reg <= 1'b0;
                    end
                end
                tsq_pkg::OP_STOP, tsq_pkg::OP_END: begin
                    done_reg    <= playing_reg;
                    compare_reg <= '0;
                    tone_reg    <= 1'b0;
                    playing_reg <= 1'b0;
                end
                tsq_pkg::OP_HALF: begin
                    half_reg    <= 1'b0;
                    compare_reg <= '0;
                end
                tsq_pkg::OP_TICK: begin
                    half_reg   <= 1'b1;
                    remain_reg <= remain_reg - 32'd1;
                end
                tsq_pkg::OP_LATCH:     note_reg     <= ram_rdata;
                tsq_pkg::OP_LATCH_ENV: note_reg.env <= ram_rdata.env;
                tsq_pkg::OP_MUL1: begin
                    fd_reg <= note_reg.freq * note_reg.dur;
                    av_reg <= amp_sat * vol_sat;
                end
                tsq_pkg::OP_MUL2: begin
                    peak_reg <= is_rest ? 16'd0 : peak_full[31:16];
                    tone_reg <= !is_rest;
                end
                tsq_pkg::OP_SET_RELOAD: begin
                    reload_reg <= (div_quotient[31:0] == 32'd0) ? 32'd0 :
                                  div_quotient[31:0] - 32'd1;
                end
                // The period count is the product scaled back by the reciprocal shift.
                tsq_pkg::OP_MUL_COUNT: cnt_prod_reg <= fd_reg * tsq_pkg::MS_RECIP;
                tsq_pkg::OP_SET_COUNT: begin
                    remain_reg <= count_fix;
                    total_reg  <= count_fix;
                end
                tsq_pkg::OP_ENV_MUL:     envp_reg    <= peak_reg * env_mult;
                tsq_pkg::OP_SET_COMPARE: compare_reg <= div_quotient[15:0];
                tsq_pkg::OP_ADVANCE:     pos_reg     <= pos_reg + 1'b1;
                tsq_pkg::OP_EMIT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= '{period_reload: reload_reg, duty_compare: compare_reg,
                                     tone_on: tone_reg, playing: playing_reg,
                                     sequence_done: done_reg};
                end
                default: ;
            endcase
        end
    end

    assign stat = '{kind: in_reg.kind, playing: playing_reg, half: half_reg,
                    div_done: div_done, remain_zero: remain_reg == 32'd0,
                    pos_end: pos_reg >= len_reg, len_zero: len_zero,
                    out_free: !m_valid_reg || m_ready};

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_tone_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == tsq_pkg::OP_EMIT && tone_reg |-> playing_reg)
        else $error("tone on without a running sequence");

    a_total_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == tsq_pkg::OP_EMIT && playing_reg |-> total_reg != 32'd0)
        else $error("running note has zero period count");

endmodule

### sv/tsq_ctrl.sv
// Controller state machine of the tone sequencer.
module tsq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tsq_pkg::stat_t stat,
    output tsq_pkg::cmd_t  cmd
);

    tsq_pkg::state_t state_reg, state_next;
    logic tick_ctx_reg, tick_ctx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsq_pkg::ST_IDLE;
            tick_ctx_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tick_ctx_reg <= tick_ctx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tick_ctx_next = tick_ctx_reg;
        cmd.op        = tsq_pkg::OP_NONE;
        s_ready       = 1'b0;
        unique case (state_reg)
            tsq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = tsq_pkg::OP_CAPTURE;
                    state_next = tsq_pkg::ST_DECODE;
                end
            end
            tsq_pkg::ST_DECODE: begin
                tick_ctx_next = 1'b0;
                unique case (stat.kind)
                    tsq_pkg::KIND_LOAD: begin
                        cmd.op     = tsq_pkg::OP_LOAD;
                        state_next = tsq_pkg::ST_EMIT;
                    end
                    tsq_pkg::KIND_PLAY: begin
                        cmd.op     = tsq_pkg::OP_PLAY;
                        state_next = stat.len_zero ? tsq_pkg::ST_EMIT : tsq_pkg::ST_RD;
                    end
                    tsq_pkg::KIND_STOP: begin
                        cmd.op     = tsq_pkg::OP_STOP;
                        state_next = tsq_pkg::ST_EMIT;
                    end
                    default: begin
                        if (!stat.playing) begin
                            state_next = tsq_pkg::ST_EMIT;
                        end else if (stat.half) begin
                            cmd.op     = tsq_pkg::OP_HALF;
                            state_next = tsq_pkg::ST_EMIT;
                        end else begin
                            cmd.op        = tsq_pkg::OP_TICK;
                            tick_ctx_next = 1'b1;
                            state_next    = tsq_pkg::ST_TRD;
                        end
                    end
                endcase
            end
            tsq_pkg::ST_RD:    state_next = tsq_pkg::ST_LATCH;
            tsq_pkg::ST_LATCH: begin
                cmd.op     = tsq_pkg::OP_LATCH;
                state_next = tsq_pkg::ST_MUL1;
            end
            tsq_pkg::ST_MUL1: begin
                cmd.op     = tsq_pkg::OP_MUL1;
                state_next = tsq_pkg::ST_MUL2;
            end
            tsq_pkg::ST_MUL2: begin
                cmd.op     = tsq_pkg::OP_MUL2;
                state_next = tsq_pkg::ST_DRL;
            end
            tsq_pkg::ST_DRL: begin
                cmd.op     = tsq_pkg::OP_DIV_RELOAD;
                state_next = tsq_pkg::ST_DRL_W;
            end
            tsq_pkg::ST_DRL_W: begin
                if (stat.div_done) begin
                    cmd.op     = tsq_pkg::OP_SET_RELOAD;
                    state_next = tsq_pkg::ST_DCT;
                end
            end
            tsq_pkg::ST_DCT: begin
                cmd.op     = tsq_pkg::OP_MUL_COUNT;
                state_next = tsq_pkg::ST_DCT_W;
            end
            tsq_pkg::ST_DCT_W: begin
                cmd.op     = tsq_pkg::OP_SET_COUNT;
                state_next = tsq_pkg::ST_ENVM;
            end
            tsq_pkg::ST_TRD:    state_next = tsq_pkg::ST_TLATCH;
            tsq_pkg::ST_TLATCH: begin
                cmd.op     = tsq_pkg::OP_LATCH_ENV;
                state_next = tsq_pkg::ST_ENVM;
            end
            tsq_pkg::ST_ENVM: begin
                cmd.op     = tsq_pkg::OP_ENV_MUL;
                state_next = tsq_pkg::ST_DEV;
            end
            tsq_pkg::ST_DEV: begin
                cmd.op     = tsq_pkg::OP_DIV_ENV;
                state_next = tsq_pkg::ST_DEV_W;
            end
            tsq_pkg::ST_DEV_W: begin
                if (stat.div_done) begin
                    cmd.op     = tsq_pkg::OP_SET_COMPARE;
                    state_next = (tick_ctx_reg && stat.remain_zero) ?
                                 tsq_pkg::ST_ADV : tsq_pkg::ST_EMIT;
                end
            end
            tsq_pkg::ST_ADV: begin
                cmd.op     = tsq_pkg::OP_ADVANCE;
                state_next = tsq_pkg::ST_CHECK;
            end
            tsq_pkg::ST_CHECK: begin
                tick_ctx_next = 1'b0;
                if (stat.pos_end) begin
                    cmd.op     = tsq_pkg::OP_END;
                    state_next = tsq_pkg::ST_EMIT;
                end else begin
                    state_next = tsq_pkg::ST_RD;
                end
            end
            tsq_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = tsq_pkg::OP_EMIT;
                    state_next = tsq_pkg::ST_IDLE;
                end
            end
            default: state_next = tsq_pkg::ST_IDLE;
        endcase
    end

endmodule

### sv/tone_sequencer_with_envelope.sv
// Top level of the tone sequencer: configuration registers, controller and datapath.
// Steps: a load, stop, idle tick, half-period tick or zero-length play goes from decode straight
// to the result register. A period-end tick makes one envelope pass of the shared divider, then
// an advance and end check if its note ran out; a play item makes two passes (reload, envelope),
// and a tick that starts the next note its own pass and both of the new note. A stalled result
// receiver adds its stall. One item at a time; the next beat is taken once the result is registered.
// Reset: aresetn is synchronous and active low; it stops playback and loads the register defaults.
module tone_sequencer_with_envelope (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsq_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsq_pkg::out_beat_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tsq_pkg::cfg_t  cfg_reg;
    tsq_pkg::cmd_t  cmd;
    tsq_pkg::stat_t stat;
    logic           wr_en;

    // Registers sit at byte addresses 0, 4 and 8; the word index is paddr[3:2].
    // A write lands in the access phase, and the port never stalls.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timer_clock_hz   <= 28'd1000000;
            cfg_reg.amp_timer_period <= 16'd999;
            cfg_reg.volume           <= 9'd256;
        end else if (wr_en) begin
            case (paddr[3:2])
                tsq_pkg::REG_TIMER_CLOCK: cfg_reg.timer_clock_hz   <= pwdata[27:0];
                tsq_pkg::REG_AMP_PERIOD:  cfg_reg.amp_timer_period <= pwdata[15:0];
                tsq_pkg::REG_VOLUME:      cfg_reg.volume           <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read data is plain combinational muxing of the stored values.
    always_comb begin
        case (paddr[3:2])
            tsq_pkg::REG_TIMER_CLOCK: prdata = 32'(cfg_reg.timer_clock_hz);
            tsq_pkg::REG_AMP_PERIOD:  prdata = 32'(cfg_reg.amp_timer_period);
            tsq_pkg::REG_VOLUME:      prdata = 32'(cfg_reg.volume);
            default:                  prdata = 32'd0;
        endcase
    end

    // The controller steps through a note start or a tick one operation per cycle, waiting on the
    // divider and the result receiver; the datapath holds all playback state and the result register.
    tsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tsq_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

### bench/tone_sequencer_with_envelope_checker.sv
// Checker for the tone sequencer: predicts every result beat and compares it.
module tone_sequencer_with_envelope_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tsq_pkg::in_beat_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tsq_pkg::out_beat_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output int                  fail_count,
    output int                  awaited,
    output int                  beats_checked,
    output int                  sequence_ends
);
    import tsq_pkg::*;

    note_t       tone_table [MAX_NOTES];
    logic [6:0]  seq_pos;
    logic [6:0]  seq_len;
    logic [31:0] periods_left;
    logic [31:0] periods_total;
    logic [15:0] peak_duty;
    logic [15:0] duty_now;
    logic [31:0] reload_now;
    logic        in_half;
    logic        is_playing;
    logic        is_tone;
    logic [27:0] clk_hz;
    logic [15:0] amp_period;
    logic [8:0]  vol;

    out_beat_t   expected_beats [$];

    function automatic logic [15:0] envelope_duty(logic [1:0] env);
        logic [63:0] p;
        p = {48'd0, peak_duty};
        if (periods_total == 0)
            return 16'd0;
        if (env == ENV_RISE)
            return 16'(p * (periods_total - periods_left) / periods_total);
        if (env == ENV_FALL)
            return 16'(p * periods_left / periods_total);
        return peak_duty;
    endfunction

    function automatic logic [31:0] reload_for(logic [31:0] f);
        logic [31:0] twice;
        twice = f * 2;
        if ({4'd0, clk_hz} < twice)
            return 32'd0;
        return {4'd0, clk_hz} / twice - 32'd1;
    endfunction

    task automatic begin_note(note_t n);
        logic [31:0] cnt;
        logic [8:0]  a;
        logic [8:0]  v;
        logic [63:0] prod;
        if (n.freq == 0) begin
            reload_now = reload_for({16'd0, REST_BASE_HZ});
            cnt = {16'd0, n.dur};
            peak_duty = 16'd0;
            is_tone = 1'b0;
        end else begin
            a = (n.amp > Q8_ONE) ? Q8_ONE : n.amp;
            v = (vol > Q8_ONE) ? Q8_ONE : vol;
            reload_now = reload_for({16'd0, n.freq});
            cnt = 32'({48'd0, n.freq} * {48'd0, n.dur} / {32'd0, MS_PER_S});
            prod = {48'd0, amp_period} * {55'd0, a} * {55'd0, v};
            peak_duty = prod[31:16];
            is_tone = 1'b1;
        end
        if (cnt == 0)
            cnt = 32'd1;
        periods_left = cnt;
        periods_total = cnt;
        duty_now = envelope_duty(n.env);
    endtask

    function automatic logic stop_playback();
        logic was;
        was = is_playing;
        duty_now = 16'd0;
        is_playing = 1'b0;
        is_tone = 1'b0;
        return was;
    endfunction

    // Applies one accepted input beat to the predicted state and queues its result.
    task automatic apply_input(in_beat_t b);
        logic      done;
        logic [6:0] len;
        out_beat_t r;
        done = 1'b0;
        case (b.kind)
            KIND_LOAD: begin
                tone_table[b.note_index] = '{b.note_freq, b.note_duration_ms,
                                             b.note_amp, b.note_envelope};
            end
            KIND_PLAY: begin
                logic was;
                was = stop_playback();
                len = (b.play_length > MAX_NOTES) ? 7'(MAX_NOTES) : b.play_length;
                if (len == 0) begin
                    done = was;
                end else begin
                    seq_pos = 7'd0;
                    seq_len = len;
                    in_half = 1'b0;
                    is_playing = 1'b1;
                    begin_note(tone_table[0]);
                end
            end
            KIND_STOP: done = stop_playback();
            default: begin
                if (is_playing) begin
                    if (in_half) begin
                        in_half = 1'b0;
                        duty_now = 16'd0;
                    end else begin
                        in_half = 1'b1;
                        periods_left = periods_left - 32'd1;
                        duty_now = envelope_duty(tone_table[seq_pos[5:0]].env);
                        if (periods_left == 0) begin
                            seq_pos = seq_pos + 7'd1;
                            if (seq_pos >= seq_len)
                                done = stop_playback();
                            else
                                begin_note(tone_table[seq_pos[5:0]]);
                        end
                    end
                end
            end
        endcase
        r.period_reload = reload_now;
        r.duty_compare  = duty_now;
        r.tone_on       = is_tone;
        r.playing       = is_playing;
        r.sequence_done = done;
        expected_beats.push_back(r);
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            seq_pos = '0;
            seq_len = '0;
            periods_left = '0;
            periods_total = '0;
            peak_duty = '0;
            duty_now = '0;
            reload_now = '0;
            in_half = 1'b0;
            is_playing = 1'b0;
            is_tone = 1'b0;
            clk_hz = 28'd1000000;
            amp_period = 16'd999;
            vol = 9'd256;
            expected_beats.delete();
            fail_count = 0;
            beats_checked = 0;
            sequence_ends = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TIMER_CLOCK: clk_hz = pwdata[27:0];
                    REG_AMP_PERIOD:  amp_period = pwdata[15:0];
                    REG_VOLUME:      vol = pwdata[8:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                apply_input(s_data);
            if (m_valid && m_ready) begin
                beats_checked++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (want.sequence_done)
                        sequence_ends++;
                    if (want.period_reload !== m_data.period_reload) begin
                        $error("period_reload expected %0d got %0d",
                               want.period_reload, m_data.period_reload);
                        fail_count++;
                    end
                    if (want.duty_compare !== m_data.duty_compare) begin
                        $error("duty_compare expected %0d got %0d",
                               want.duty_compare, m_data.duty_compare);
                        fail_count++;
                    end
                    if (want.tone_on !== m_data.tone_on) begin
                        $error("tone_on expected %0d got %0d", want.tone_on, m_data.tone_on);
                        fail_count++;
                    end
                    if (want.playing !== m_data.playing) begin
                        $error("playing expected %0d got %0d", want.playing, m_data.playing);
                        fail_count++;
                    end
                    if (want.sequence_done !== m_data.sequence_done) begin
                        $error("sequence_done expected %0d got %0d",
                               want.sequence_done, m_data.sequence_done);
                        fail_count++;
                    end
                end
            end
        end
        awaited = expected_beats.size();
    end

endmodule

### bench/tone_sequencer_with_envelope_tb.sv
// Testbench top of the tone sequencer: clock, reset, stimulus and verdict.
module tone_sequencer_with_envelope_tb;
    import tsq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 275;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    int fail_count;
    int awaited;
    int beats_checked;
    int sequence_ends;

    // Idle percentages for the two sides; each phase sets them anew.
    int send_idle = 0;
    int recv_idle = 0;
    int beats_sent = 0;
    int cycles = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;

    always #5 aclk = ~aclk;

    tone_sequencer_with_envelope i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tone_sequencer_with_envelope_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .awaited       (awaited),
        .beats_checked (beats_checked),
        .sequence_ends (sequence_ends)
    );

    // A free-running cycle count guards against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tone_sequencer_with_envelope regression: fail");
            $finish;
        end
    end

    // The receiver stalls at random. Once, on request, it holds off for a long
    // stretch so that the block fills up and stops taking input beats.
    always @(posedge aclk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= 800;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offers one beat, after a random gap, and waits until it is taken.
    task automatic send_beat(in_beat_t b);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Drops valid and waits until every queued result has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Setup cycle and access cycle of one register write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic in_beat_t make_beat(logic [1:0] kind, logic [5:0] idx,
                                           logic [15:0] freq, logic [15:0] dur,
                                           logic [8:0] amp, logic [1:0] env,
                                           logic [6:0] len);
        in_beat_t b;
        b = '{kind, idx, freq, dur, amp, env, len};
        return b;
    endfunction

    // A load beat whose note is usually short, so that sequences end by themselves.
    function automatic in_beat_t short_note_load(logic [5:0] idx);
        in_beat_t b;
        logic [63:0] raw;
        int periods;
        raw = {$urandom(), $urandom()};
        b = raw[57:0];
        b.kind = KIND_LOAD;
        b.note_index = idx;
        if ($urandom_range(7) == 0) begin
            b.note_freq = 16'd0;
            b.note_duration_ms = 16'($urandom_range(5));
        end else if ($urandom_range(19) != 0) begin
            b.note_freq = ($urandom_range(1)) ? 16'($urandom_range(2000, 1))
                                              : 16'($urandom_range(65535, 1));
            periods = $urandom_range(6);
            b.note_duration_ms = 16'((periods * 1000) / b.note_freq);
        end
        return b;
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t b;
        logic [63:0] raw;
        int pick;
        raw = {$urandom(), $urandom()};
        b = raw[57:0];
        pick = $urandom_range(99);
        if (pick < 68) begin
            b.kind = KIND_TICK;
        end else if (pick < 84) begin
            b = short_note_load(($urandom_range(9) < 7) ? 6'($urandom_range(7))
                                                        : 6'($urandom_range(63)));
        end else if (pick < 94) begin
            b.kind = KIND_PLAY;
            if ($urandom_range(99) < 85)
                b.play_length = 7'($urandom_range(6, 1));
        end else begin
            b.kind = KIND_STOP;
        end
        return b;
    endfunction

    initial begin
        logic [31:0] clk_sets [PHASES];
        logic [31:0] amp_sets [PHASES];
        logic [31:0] vol_sets [PHASES];

        clk_sets = '{32'd1000000, 32'd200000000, 32'd1, 32'h0FFFFFFF, 32'd48000000, 32'd0};
        amp_sets = '{32'd999, 32'd65535, 32'd0, 32'd65535, 32'd4095, 32'd1};
        vol_sets = '{32'd256, 32'd256, 32'd0, 32'd511, 32'd128, 32'd255};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every slot gets a note first, so that playback never reads an empty slot.
        for (int i = 0; i < MAX_NOTES; i++)
            send_beat(short_note_load(6'(i)));

        // Directed beats. An extreme note with every field at its top, with
        // saturated amplitude and envelope code 3, is played and then cut short.
        send_beat(make_beat(KIND_LOAD, 6'd0, 16'hFFFF, 16'hFFFF, 9'h1FF, 2'd3, 7'd0));
        send_beat(make_beat(KIND_PLAY, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd1));
        send_beat(make_beat(KIND_TICK, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_TICK, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_STOP, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_STOP, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_TICK, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        // A rest of zero length, a note whose count rounds to zero, then a
        // flat note of two periods; the sequence runs to its natural end.
        send_beat(make_beat(KIND_LOAD, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_LOAD, 6'd1, 16'd1, 16'd0, 9'd0, 2'd1, 7'd0));
        send_beat(make_beat(KIND_LOAD, 6'd2, 16'd1000, 16'd2, 9'd256, 2'd2, 7'd0));
        send_beat(make_beat(KIND_LOAD, 6'd63, 16'd3000, 16'd1, 9'd100, 2'd0, 7'd0));
        send_beat(make_beat(KIND_PLAY, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd3));
        repeat (8)
            send_beat(make_beat(KIND_TICK, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        // A long play request is cut to the table size; a zero-length play stops it.
        send_beat(make_beat(KIND_PLAY, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd127));
        send_beat(make_beat(KIND_TICK, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        send_beat(make_beat(KIND_PLAY, 6'd0, 16'd0, 16'd0, 9'd0, 2'd0, 7'd0));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Registers change only while the block is idle.
            write_reg(REG_TIMER_CLOCK, clk_sets[ph]);
            write_reg(REG_AMP_PERIOD, amp_sets[ph]);
            write_reg(REG_VOLUME, vol_sets[ph]);
            if (ph < 2) begin
                send_idle = 16;
                recv_idle = 63;
            end else if (ph < 4) begin
                send_idle = 63;
                recv_idle = 16;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In the first unthrottled phase the receiver holds off for a
                // long stretch while beats keep coming.
                if (ph == 4 && n == 40)
                    hold_req = 1'b1;
                send_beat(random_beat());
            end
            // The sender pauses until every result of the phase has come.
            drain();
        end

        while (awaited != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d input beats over %0d register settings; %0d result beats checked.",
                 beats_sent, PHASES, beats_checked);
        $display("Sequences that ended: %0d.", sequence_ends);
        if (fail_count == 0 && awaited == 0) begin
            $display("tone_sequencer_with_envelope regression: pass");
        end else begin
            $display("tone_sequencer_with_envelope regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
sv/tsq_pkg.sv
sv/tsq_ram.sv
sv/tsq_div.sv
sv/tsq_datapath.sv
sv/tsq_ctrl.sv
sv/tone_sequencer_with_envelope.sv
bench/tone_sequencer_with_envelope_checker.sv
bench/tone_sequencer_with_envelope_tb.sv
